>>> design/fcull_pkg.sv
// ----------------------------------------------------------------------------
// fcull_pkg
// shared types and constants for the frustum cull test unit
// ----------------------------------------------------------------------------
package fcull_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd5;

	// test kinds
	localparam logic [1:0] ACT_POINT  = 2'd0;
	localparam logic [1:0] ACT_SPHERE = 2'd1;
	localparam logic [1:0] ACT_BOX    = 2'd2;
	localparam logic [1:0] ACT_RSVD   = 2'd3;

	// packed plane, normals q2.14, offset in coordinate units
	typedef struct packed {
		logic signed [15:0] offset;
		logic signed [15:0] nz;
		logic signed [15:0] ny;
		logic signed [15:0] nx;
	} plane_t;

endpackage

>>> design/fcull_plane.sv
// ----------------------------------------------------------------------------
// fcull_plane
// pipelined sign test of the signed distance of one object against one plane, three stages
// ----------------------------------------------------------------------------
module fcull_plane import fcull_pkg::*; #(
	parameter int COORD_WIDTH      = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  plane_t                        plane,
	input  logic                          is_box,
	input  logic                          is_sphere,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	input  logic signed [COORD_WIDTH-1:0] corner_x,
	input  logic signed [COORD_WIDTH-1:0] corner_y,
	input  logic signed [COORD_WIDTH-1:0] corner_z,
	input  logic        [COORD_WIDTH-1:0] sphere_radius,
	output logic                          reject
);

	localparam int PW  = 16 + COORD_WIDTH;
	localparam int KW  = ((COORD_WIDTH + 1 > 16) ? COORD_WIDTH + 1 : 16) + 1;
	localparam int SKW = KW + NORMAL_FRAC_BITS;
	localparam int DW  = ((PW > SKW) ? PW : SKW) + 2;

	logic signed [COORD_WIDTH-1:0] vx, vy, vz;
	logic signed [KW-1:0]          k;
	logic signed [PW-1:0]          prod_x_s2, prod_y_s2, prod_z_s2;
	logic signed [KW-1:0]          k_s2;
	logic signed [DW-1:0]          sum_a_s3, sum_b_s3;
	logic signed [DW-1:0]          total;
	logic                          reject_s4;

	// positive vertex for box, plain position otherwise
	always_comb begin
		vx = (is_box && !plane.nx[15]) ? corner_x : pos_x;
		vy = (is_box && !plane.ny[15]) ? corner_y : pos_y;
		vz = (is_box && !plane.nz[15]) ? corner_z : pos_z;
		k  = KW'(plane.offset) + (is_sphere ? KW'({1'b0, sphere_radius}) : KW'(0));
	end

	always_ff @(posedge clk) begin
		prod_x_s2 <= PW'(plane.nx) * PW'(vx);
		prod_y_s2 <= PW'(plane.ny) * PW'(vy);
		prod_z_s2 <= PW'(plane.nz) * PW'(vz);
		k_s2      <= k;
	end

	always_ff @(posedge clk) begin
		sum_a_s3 <= DW'(prod_x_s2) + DW'(prod_y_s2);
		sum_b_s3 <= DW'(prod_z_s2) + (DW'(k_s2) <<< NORMAL_FRAC_BITS);
	end

	assign total = sum_a_s3 + sum_b_s3;

	always_ff @(posedge clk) begin
		reject_s4 <= total[DW-1];
	end

	assign reject = reject_s4;

endmodule

>>> design/frustum_cull_test_unit.sv
// ----------------------------------------------------------------------------
// frustum_cull_test_unit
// tests a point, sphere or box against six configured frustum planes
//
// channel   ports                                        handshake
// -------   -------------------------------------------  ----------------------
// in        action pos_* corner_* sphere_radius          start high, busy low
// out       visible                                      done strobe, one cycle
// cfg       cfg_index cfg_data                           cfg_we, no wait
//
// one beat per cycle; the result passes the input register, the multiply,
// two adder stages and the plane reduce before it appears with done
// busy stays low: the pipeline never stalls as the receiver cannot hold off
// reset clears the planes (all objects visible) and the valid bits
// ----------------------------------------------------------------------------
module frustum_cull_test_unit import fcull_pkg::*; #(
	parameter int COORD_WIDTH      = 16,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    action,
	input  logic signed [COORD_WIDTH-1:0] pos_x,
	input  logic signed [COORD_WIDTH-1:0] pos_y,
	input  logic signed [COORD_WIDTH-1:0] pos_z,
	input  logic signed [COORD_WIDTH-1:0] corner_x,
	input  logic signed [COORD_WIDTH-1:0] corner_y,
	input  logic signed [COORD_WIDTH-1:0] corner_z,
	input  logic        [COORD_WIDTH-1:0] sphere_radius,
	output logic                          done,
	output logic                          visible,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	plane_t                        plane_q [PLANE_COUNT];
	logic                          valid_s1, valid_s2, valid_s3, valid_s4;
	logic                          is_box_s1, is_sphere_s1;
	logic signed [COORD_WIDTH-1:0] pos_x_s1, pos_y_s1, pos_z_s1;
	logic signed [COORD_WIDTH-1:0] corner_x_s1, corner_y_s1, corner_z_s1;
	logic        [COORD_WIDTH-1:0] radius_s1;
	logic [PLANE_COUNT-1:0]        reject;
	logic                          done_q, visible_q;

	assign busy = 1'b0;

	// plane registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PLANE_COUNT; i++) plane_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PLANE_LEFT:   plane_q[0] <= cfg_data;
				REG_PLANE_RIGHT:  plane_q[1] <= cfg_data;
				REG_PLANE_TOP:    plane_q[2] <= cfg_data;
				REG_PLANE_BOTTOM: plane_q[3] <= cfg_data;
				REG_PLANE_NEAR:   plane_q[4] <= cfg_data;
				REG_PLANE_FAR:    plane_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		is_box_s1    <= (action == ACT_BOX) || (action == ACT_RSVD);
		is_sphere_s1 <= (action == ACT_SPHERE);
		pos_x_s1     <= pos_x;
		pos_y_s1     <= pos_y;
		pos_z_s1     <= pos_z;
		corner_x_s1  <= corner_x;
		corner_y_s1  <= corner_y;
		corner_z_s1  <= corner_z;
		radius_s1    <= sphere_radius;
	end

	// valid bits and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done_q   <= valid_s4;
		end
	end

	for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
		fcull_plane #(
			.COORD_WIDTH      (COORD_WIDTH),
			.NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
		) u_plane (
			.clk           (clk),
			.plane         (plane_q[g]),
			.is_box        (is_box_s1),
			.is_sphere     (is_sphere_s1),
			.pos_x         (pos_x_s1),
			.pos_y         (pos_y_s1),
			.pos_z         (pos_z_s1),
			.corner_x      (corner_x_s1),
			.corner_y      (corner_y_s1),
			.corner_z      (corner_z_s1),
			.sphere_radius (radius_s1),
			.reject        (reject[g])
		);
	end

	always_ff @(posedge clk) begin
		visible_q <= ~|reject;
	end

	assign done    = done_q;
	assign visible = visible_q;

	// every accepted beat gives exactly one result on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("result beat missing after accept");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result beat without accepted item");

	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |=> done)
		else $error("valid lost between last stage and output");

endmodule

>>> tb/sv/frustum_cull_test_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_test_unit_test
// self-checking bench for the frustum cull test unit
//
// a queue of pending beats and plane writes, filled up front, feeds a clocked
// driver. every accepted beat is run through a local visibility predictor
// built on a mirror of the six plane registers, and the expected flag is
// queued. a clocked monitor pops it on each done strobe and compares.
// plane writes wait until every expected result has come back. directed
// objects cover boundaries, extremes, the unused selector and inverted boxes;
// random phases follow with varied planes and sender idling.
// ----------------------------------------------------------------------------
module frustum_cull_test_unit_test;
	import fcull_pkg::*;

	localparam int CW = 16;
	localparam longint NORM_ONE = 64'sd16384;

	typedef enum {OP_BEAT, OP_WRITE, OP_DRAIN} op_kind_t;

	typedef struct {
		logic [1:0]           action;
		logic signed [CW-1:0] pos_x;
		logic signed [CW-1:0] pos_y;
		logic signed [CW-1:0] pos_z;
		logic signed [CW-1:0] corner_x;
		logic signed [CW-1:0] corner_y;
		logic signed [CW-1:0] corner_z;
		logic [CW-1:0]        radius;
	} cull_obj_t;

	typedef struct {
		op_kind_t              op;
		int                    idle_pct;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		cull_obj_t             obj;
	} stim_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [1:0]            action = ACT_POINT;
	logic signed [CW-1:0]  pos_x = '0;
	logic signed [CW-1:0]  pos_y = '0;
	logic signed [CW-1:0]  pos_z = '0;
	logic signed [CW-1:0]  corner_x = '0;
	logic signed [CW-1:0]  corner_y = '0;
	logic signed [CW-1:0]  corner_z = '0;
	logic [CW-1:0]         sphere_radius = '0;
	logic                  done;
	logic                  visible;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_PLANE_LEFT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	stim_t                 pending_q[$];
	bit                    visible_q[$];
	logic [CFG_DATA_W-1:0] plane_mirror[PLANE_COUNT];
	cull_obj_t             cur_obj;
	int                    mismatch_cnt = 0;

	frustum_cull_test_unit #(
		.COORD_WIDTH(CW),
		.NORMAL_FRAC_BITS(14)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.corner_x(corner_x),
		.corner_y(corner_y),
		.corner_z(corner_z),
		.sphere_radius(sphere_radius),
		.done(done),
		.visible(visible),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic bit cull_visible(cull_obj_t o);
		plane_t pl;
		longint nx, ny, nz, off, px, py, pz, cx, cy, cz, rad, vx, vy, vz, plane_d;
		bit vis;
		px = o.pos_x;
		py = o.pos_y;
		pz = o.pos_z;
		cx = o.corner_x;
		cy = o.corner_y;
		cz = o.corner_z;
		rad = o.radius;
		rad = rad * NORM_ONE;
		vis = 1'b1;
		for (int i = 0; i < PLANE_COUNT; i++) begin
			pl = plane_mirror[i];
			nx = $signed(pl.nx);
			ny = $signed(pl.ny);
			nz = $signed(pl.nz);
			off = $signed(pl.offset);
			if (o.action == ACT_BOX || o.action == ACT_RSVD) begin
				vx = (nx >= 0) ? cx : px;
				vy = (ny >= 0) ? cy : py;
				vz = (nz >= 0) ? cz : pz;
				plane_d = nx * vx + ny * vy + nz * vz + off * NORM_ONE;
				if (plane_d < 0)
					vis = 1'b0;
			end else begin
				plane_d = nx * px + ny * py + nz * pz + off * NORM_ONE;
				if (o.action == ACT_SPHERE) begin
					if (plane_d < -rad)
						vis = 1'b0;
				end else if (plane_d < 0) begin
					vis = 1'b0;
				end
			end
		end
		return vis;
	endfunction

	task automatic report_mismatch(string what, logic got, logic want);
		$display("%0t: %s: visible %b, expected %b", $time, what, got, want);
		mismatch_cnt++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		stim_t head;
		bit beat_go;
		bit write_go;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			for (int i = 0; i < PLANE_COUNT; i++)
				plane_mirror[i] = '0;
		end else begin
			beat_go = 1'b0;
			write_go = 1'b0;
			if (start && !busy)
				visible_q.push_back(cull_visible(cur_obj));
			if (!start || !busy) begin
				if (pending_q.size() > 0) begin
					head = pending_q[0];
					case (head.op)
						OP_BEAT: begin
							if ($urandom_range(0, 99) >= head.idle_pct) begin
								beat_go = 1'b1;
								cur_obj = head.obj;
								void'(pending_q.pop_front());
							end
						end
						OP_WRITE: begin
							if (visible_q.size() == 0) begin
								write_go = 1'b1;
								plane_mirror[head.idx] = head.data;
								void'(pending_q.pop_front());
							end
						end
						default: begin
							if (visible_q.size() == 0)
								void'(pending_q.pop_front());
						end
					endcase
				end
				start <= beat_go;
				if (beat_go) begin
					action <= cur_obj.action;
					pos_x <= cur_obj.pos_x;
					pos_y <= cur_obj.pos_y;
					pos_z <= cur_obj.pos_z;
					corner_x <= cur_obj.corner_x;
					corner_y <= cur_obj.corner_y;
					corner_z <= cur_obj.corner_z;
					sphere_radius <= cur_obj.radius;
				end
			end
			cfg_we <= write_go;
			if (write_go) begin
				cfg_index <= head.idx;
				cfg_data <= head.data;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		bit want;
		if (arst_n && done) begin
			if (visible_q.size() == 0) begin
				report_mismatch("result with nothing expected", visible, 1'bx);
			end else begin
				want = visible_q.pop_front();
				if (visible !== want)
					report_mismatch("wrong visibility", visible, want);
			end
		end
	end

	function automatic cull_obj_t obj_of(logic [1:0] act, int px, int py, int pz,
			int cx, int cy, int cz, int r);
		cull_obj_t o;
		o.action = act;
		o.pos_x = px[CW-1:0];
		o.pos_y = py[CW-1:0];
		o.pos_z = pz[CW-1:0];
		o.corner_x = cx[CW-1:0];
		o.corner_y = cy[CW-1:0];
		o.corner_z = cz[CW-1:0];
		o.radius = r[CW-1:0];
		return o;
	endfunction

	function automatic logic signed [CW-1:0] rand_coord();
		int v;
		if ($urandom_range(0, 99) < 20)
			v = $urandom;
		else
			v = int'($urandom_range(0, 6000)) - 3000;
		return v[CW-1:0];
	endfunction

	function automatic logic signed [CW-1:0] rand_corner(logic signed [CW-1:0] p);
		int base;
		if ($urandom_range(0, 99) < 15)
			return rand_coord();
		base = p;
		base = base + int'($urandom_range(0, 1500));
		return base[CW-1:0];
	endfunction

	function automatic cull_obj_t rand_obj();
		cull_obj_t o;
		if ($urandom_range(0, 99) < 6)
			o.action = ACT_RSVD;
		else
			o.action = 2'($urandom_range(0, 2));
		o.pos_x = rand_coord();
		o.pos_y = rand_coord();
		o.pos_z = rand_coord();
		o.corner_x = rand_corner(o.pos_x);
		o.corner_y = rand_corner(o.pos_y);
		o.corner_z = rand_corner(o.pos_z);
		if ($urandom_range(0, 99) < 70)
			o.radius = 16'($urandom_range(0, 1500));
		else
			o.radius = 16'($urandom);
		return o;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pack_plane(int nx, int ny, int nz, int off);
		plane_t p;
		p.nx = nx[15:0];
		p.ny = ny[15:0];
		p.nz = nz[15:0];
		p.offset = off[15:0];
		return p;
	endfunction

	// roughly axis-aligned frustum face with jittered normal and offset
	function automatic logic [CFG_DATA_W-1:0] frustum_plane(int which);
		int n[3];
		int axis;
		int off;
		for (int k = 0; k < 3; k++)
			n[k] = int'($urandom_range(0, 6000)) - 3000;
		axis = which / 2;
		n[axis] = int'($urandom_range(12000, 16384));
		if (which == 1 || which == 2 || which == 5)
			n[axis] = -n[axis];
		if (which == 4)
			off = $urandom_range(0, 500);
		else if (which == 5)
			off = $urandom_range(1000, 6000);
		else
			off = $urandom_range(500, 4000);
		return pack_plane(n[0], n[1], n[2], off);
	endfunction

	task automatic queue_object(cull_obj_t o, int pct);
		stim_t s;
		s.op = OP_BEAT;
		s.idle_pct = pct;
		s.idx = REG_PLANE_LEFT;
		s.data = '0;
		s.obj = o;
		pending_q.push_back(s);
	endtask

	task automatic queue_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		stim_t s;
		s.op = OP_WRITE;
		s.idle_pct = 0;
		s.idx = idx;
		s.data = data;
		s.obj = obj_of(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
		pending_q.push_back(s);
	endtask

	task automatic queue_drain();
		stim_t s;
		s.op = OP_DRAIN;
		s.idle_pct = 0;
		s.idx = REG_PLANE_LEFT;
		s.data = '0;
		s.obj = obj_of(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
		pending_q.push_back(s);
	endtask

	task automatic write_all(logic [CFG_DATA_W-1:0] data);
		for (int i = 0; i < PLANE_COUNT; i++)
			queue_write(i[CFG_IDX_W-1:0], data);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] ext_tab[4];
		int idle_tab[4];
		ext_tab = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_8000_8000_8000,
			64'h7FFF_7FFF_7FFF_7FFF};
		idle_tab = '{0, 51, 0, 9};

		// planes cleared by reset: everything visible
		queue_object(obj_of(ACT_POINT, -32768, -32768, -32768, 0, 0, 0, 0), 0);
		queue_object(obj_of(ACT_RSVD, 32767, 32767, 32767, -32768, -32768, -32768, 0), 0);
		queue_object(obj_of(ACT_SPHERE, 32767, -32768, 0, 0, 0, 0, 0), 0);

		// box frustum: |x| <= 1000, |y| <= 1000, 0 <= z <= 3000
		queue_write(REG_PLANE_LEFT, pack_plane(16384, 0, 0, 1000));
		queue_write(REG_PLANE_RIGHT, pack_plane(-16384, 0, 0, 1000));
		queue_write(REG_PLANE_TOP, pack_plane(0, -16384, 0, 1000));
		queue_write(REG_PLANE_BOTTOM, pack_plane(0, 16384, 0, 1000));
		queue_write(REG_PLANE_NEAR, pack_plane(0, 0, 16384, 0));
		queue_write(REG_PLANE_FAR, pack_plane(0, 0, -16384, 3000));
		queue_object(obj_of(ACT_POINT, 0, 0, 100, 0, 0, 0, 0), 0);
		queue_object(obj_of(ACT_POINT, -1000, 0, 100, 0, 0, 0, 0), 0);
		queue_object(obj_of(ACT_POINT, -1001, 0, 100, 0, 0, 0, 0), 0);
		queue_object(obj_of(ACT_POINT, 32767, 32767, 32767, -32768, -32768, -32768, 65535), 0);
		queue_object(obj_of(ACT_SPHERE, 1500, 0, 100, 0, 0, 0, 499), 0);
		queue_object(obj_of(ACT_SPHERE, 1500, 0, 100, 0, 0, 0, 500), 0);
		queue_object(obj_of(ACT_SPHERE, -32768, -32768, -32768, 0, 0, 0, 65535), 0);
		queue_object(obj_of(ACT_SPHERE, 0, 0, -1, 32767, 32767, 32767, 0), 0);
		queue_object(obj_of(ACT_BOX, -2000, -2000, -2000, -1500, 0, 0, 0), 0);
		queue_object(obj_of(ACT_BOX, -2000, -2000, -2000, 2000, 2000, 2000, 65535), 0);
		// inverted box
		queue_object(obj_of(ACT_BOX, 500, 500, 500, -500, -500, -500, 0), 0);
		queue_object(obj_of(ACT_RSVD, -2000, -2000, -2000, 2000, 2000, 2000, 0), 0);
		queue_object(obj_of(ACT_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0), 0);

		// extreme plane words
		for (int e = 1; e < 4; e++) begin
			write_all(ext_tab[e]);
			queue_object(obj_of(ACT_POINT, 0, 0, 0, 0, 0, 0, 0), 0);
			queue_object(obj_of(ACT_SPHERE, -32768, 32767, -32768, 0, 0, 0, 65535), 0);
		end

		for (int p = 0; p < 10; p++) begin
			for (int i = 0; i < PLANE_COUNT; i++) begin
				if (p == 3)
					queue_write(i[CFG_IDX_W-1:0], {$urandom, $urandom});
				else if (p == 6 && $urandom_range(0, 1))
					queue_write(i[CFG_IDX_W-1:0], ext_tab[$urandom_range(0, 3)]);
				else
					queue_write(i[CFG_IDX_W-1:0], frustum_plane(i));
			end
			for (int k = 0; k < 125; k++) begin
				if (k == 62)
					queue_drain();
				queue_object(rand_obj(), idle_tab[p % 4]);
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_q.size() > 0 || visible_q.size() > 0 || start);
		repeat (20) @(negedge clk);

		if (mismatch_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
